@@ sv/bptc_pkg.sv @@
// Package: shared constants, register indexes and types for the baro compensation block.
package bptc_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_SENS      = 3'd0;
    localparam logic [2:0] REG_OFF       = 3'd1;
    localparam logic [2:0] REG_SENS_TEMP = 3'd2;
    localparam logic [2:0] REG_OFF_TEMP  = 3'd3;
    localparam logic [2:0] REG_REF_TEMP  = 3'd4;
    localparam logic [2:0] REG_TEMP_SENS = 3'd5;
    localparam logic [2:0] REG_SO_ENABLE = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int RAW_W  = 24;
    localparam int PRES_W = 17;
    localparam int TEMP_W = 16;

    // 20.00 degrees offset and the -15.00 degree knee relative to it
    localparam logic signed [18:0] TEMP_REF  = 19'sd2000;
    localparam logic signed [17:0] KNEE_DIFF = 18'sd3500;
    localparam logic signed [18:0] KNEE_OFS  = 19'sd3500;

    localparam logic signed [19:0] TEMP_MIN = -20'sd32768;
    localparam logic signed [19:0] TEMP_MAX = 20'sd32767;
    localparam logic signed [28:0] PRES_MAX = 29'sd131071;

    // wide multiplier split point
    localparam int SPLIT_W = 20;

    typedef struct packed {
        logic pp_en;   // load partial products
        logic sum_en;  // load combined product
    } mul_ctl_t;

endpackage

@@ sv/bptc_wide_mul.sv @@
// Two-stage 24 x 40 signed multiplier built from two narrow partial products.
module bptc_wide_mul (
    input  logic                   aclk,
    input  bptc_pkg::mul_ctl_t     ctl,
    input  logic [23:0]            a,
    input  logic signed [39:0]     b,
    output logic signed [63:0]     p
);
    import bptc_pkg::*;

    logic        [43:0] lo_next, lo_reg;
    logic signed [44:0] hi_full;
    logic signed [43:0] hi_reg;
    logic signed [63:0] sum_next, sum_reg;

    always_comb begin
        lo_next  = a * b[SPLIT_W-1:0];
        hi_full  = $signed({1'b0, a}) * $signed(b[39:SPLIT_W]);
        sum_next = $signed({hi_reg, {SPLIT_W{1'b0}}}) + $signed({20'b0, lo_reg});
    end

    always_ff @(posedge aclk) begin
        if (ctl.pp_en) begin
            lo_reg <= lo_next;
            hi_reg <= hi_full[43:0];
        end
        if (ctl.sum_en) begin
            sum_reg <= sum_next;
        end
    end

    assign p = sum_reg;

endmodule

@@ sv/baro_pressure_temp_compensation_top.sv @@
// Top level: pipelined barometric pressure and temperature compensation.
//
// Each input transaction carries one raw pressure / raw temperature pair and
// yields exactly one result transaction with pressure in pascals (saturated to
// 0..131071) and temperature in hundredths of a degree (saturated to 16-bit
// two's complement). The datapath is an 11-stage pipeline: one pair enters per
// clock while the output is not stalled, and its result is presented from the
// stage 11 output register. The depth is set by the chain of multiplies: the
// coefficient products, the squares for the low-temperature correction, and
// the final 24 x 40 bit pressure product, which is split into two narrow
// partial products over two stages. Each stage advances when its successor
// can take its data, so bubbles close up and a stall at the output loses and
// repeats nothing. Calibration words are written through the cfg port, one
// register per transaction, and should only change while the pipe is empty.
module baro_pressure_temp_compensation_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [23:0] raw_pressure, [47:24] raw_temperature
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [16:0] pressure_pa, [32:17] temperature_centi, rest 0
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import bptc_pkg::*;

    localparam int NSTG = 11;

    // ---------------- configuration registers ----------------
    logic [15:0] c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;
    logic        so_en_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg    <= '0;
            c2_reg    <= '0;
            c3_reg    <= '0;
            c4_reg    <= '0;
            c5_reg    <= '0;
            c6_reg    <= '0;
            so_en_reg <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SENS:      c1_reg    <= cfg_data;
                REG_OFF:       c2_reg    <= cfg_data;
                REG_SENS_TEMP: c3_reg    <= cfg_data;
                REG_OFF_TEMP:  c4_reg    <= cfg_data;
                REG_REF_TEMP:  c5_reg    <= cfg_data;
                REG_TEMP_SENS: c6_reg    <= cfg_data;
                REG_SO_ENABLE: so_en_reg <= cfg_data[0];
                default: ;     // unmapped index, write dropped
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic [NSTG:1] vld_reg;
    logic [NSTG:1] stg_en;
    logic [NSTG:1] vld_in;

    // a stage loads when it is empty or its successor loads
    always_comb begin
        stg_en[NSTG] = ~vld_reg[NSTG] | m_axis_tready;
        for (int i = NSTG - 1; i >= 1; i--) begin
            stg_en[i] = ~vld_reg[i] | stg_en[i+1];
        end
    end

    assign vld_in        = {vld_reg[NSTG-1:1], s_axis_tvalid};
    assign s_axis_tready = stg_en[1];
    assign m_axis_tvalid = vld_reg[NSTG];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 1; i <= NSTG; i++) begin
                if (stg_en[i]) vld_reg[i] <= vld_in[i];
            end
        end
    end

    // ---------------- stage 1: dT = D2 - C5*256 ----------------
    logic [23:0]        d1_1_reg;
    logic signed [24:0] dt_next, dt_1_reg;

    assign dt_next = $signed({1'b0, s_axis_tdata[47:24]}) - $signed({1'b0, c5_reg, 8'h00});

    always_ff @(posedge aclk) begin
        if (stg_en[1]) begin
            d1_1_reg <= s_axis_tdata[23:0];
            dt_1_reg <= dt_next;
        end
    end

    // ---------------- stage 2: coefficient products ----------------
    logic [23:0]        d1_2_reg;
    logic signed [41:0] m6_next, m4_next, m3_next;
    logic signed [41:0] m6_2_reg, m4_2_reg, m3_2_reg;
    logic signed [49:0] mdd_next, mdd_2_reg;

    always_comb begin
        m6_next  = dt_1_reg * $signed({1'b0, c6_reg});
        m4_next  = dt_1_reg * $signed({1'b0, c4_reg});
        m3_next  = dt_1_reg * $signed({1'b0, c3_reg});
        mdd_next = dt_1_reg * dt_1_reg;
    end

    always_ff @(posedge aclk) begin
        if (stg_en[2]) begin
            d1_2_reg  <= d1_1_reg;
            m6_2_reg  <= m6_next;
            m4_2_reg  <= m4_next;
            m3_2_reg  <= m3_next;
            mdd_2_reg <= mdd_next;
        end
    end

    // ---------------- stage 3: TEMP, OFF, SENS, T2 ----------------
    // divides truncate toward zero: bias negative values before the shift
    logic signed [41:0] t6, t4, t3;
    logic signed [17:0] q6_next, q6_3_reg;
    logic signed [33:0] q4;
    logic signed [32:0] q3;
    logic signed [18:0] b_next, b_3_reg, temp_next, temp_3_reg;
    logic signed [34:0] off_next, off_3_reg;
    logic signed [33:0] sens_next, sens_3_reg;
    logic [16:0]        t2_next, t2_3_reg;
    logic               lt_next, lt2_next, lt_3_reg, lt2_3_reg;
    logic [23:0]        d1_3_reg;

    always_comb begin
        t6        = m6_2_reg + $signed({19'b0, {23{m6_2_reg[41]}}});
        t4        = m4_2_reg + $signed({35'b0, {7{m4_2_reg[41]}}});
        t3        = m3_2_reg + $signed({34'b0, {8{m3_2_reg[41]}}});
        q6_next   = t6[40:23];
        q4        = t4[40:7];
        q3        = t3[40:8];
        temp_next = TEMP_REF + {q6_next[17], q6_next};
        b_next    = KNEE_OFS + {q6_next[17], q6_next};
        off_next  = $signed({3'b0, c2_reg, 16'h0000}) + {q4[33], q4};
        sens_next = $signed({3'b0, c1_reg, 15'h0000}) + {q3[32], q3};
        t2_next   = mdd_2_reg[47:31];
        lt_next   = so_en_reg & q6_next[17];
        lt2_next  = so_en_reg & (q6_next < -KNEE_DIFF);
    end

    always_ff @(posedge aclk) begin
        if (stg_en[3]) begin
            d1_3_reg   <= d1_2_reg;
            q6_3_reg   <= q6_next;
            b_3_reg    <= b_next;
            temp_3_reg <= temp_next;
            off_3_reg  <= off_next;
            sens_3_reg <= sens_next;
            t2_3_reg   <= t2_next;
            lt_3_reg   <= lt_next;
            lt2_3_reg  <= lt2_next;
        end
    end

    // ---------------- stage 4: squares, final temperature ----------------
    logic signed [35:0] sq_full;
    logic signed [37:0] sq2_full;
    logic [33:0]        sq_4_reg, sq2_4_reg;
    logic signed [19:0] tc_wide;
    logic [15:0]        tc_next;
    logic               lt_4_reg, lt2_4_reg;
    logic signed [34:0] off_4_reg;
    logic signed [33:0] sens_4_reg;
    logic [23:0]        d1_4_reg;
    logic [15:0]        tc_4_reg;

    always_comb begin
        sq_full  = q6_3_reg * q6_3_reg;
        sq2_full = b_3_reg * b_3_reg;
        tc_wide  = {temp_3_reg[18], temp_3_reg};
        if (lt_3_reg) tc_wide = tc_wide - $signed({3'b0, t2_3_reg});
        if (tc_wide < TEMP_MIN)      tc_next = TEMP_MIN[15:0];
        else if (tc_wide > TEMP_MAX) tc_next = TEMP_MAX[15:0];
        else                         tc_next = tc_wide[15:0];
    end

    always_ff @(posedge aclk) begin
        if (stg_en[4]) begin
            d1_4_reg   <= d1_3_reg;
            sq_4_reg   <= sq_full[33:0];
            sq2_4_reg  <= sq2_full[33:0];   // meaningful only below the knee
            lt_4_reg   <= lt_3_reg;
            lt2_4_reg  <= lt2_3_reg;
            off_4_reg  <= off_3_reg;
            sens_4_reg <= sens_3_reg;
            tc_4_reg   <= tc_next;
        end
    end

    // ---------------- stage 5: OFF2, SENS2 ----------------
    logic [36:0] sq5, sq2x7;
    logic [37:0] sq2x11;
    logic [37:0] off2_next, sens2_next, off2_5_reg, sens2_5_reg;
    logic signed [34:0] off_5_reg;
    logic signed [33:0] sens_5_reg;
    logic [23:0]        d1_5_reg;
    logic [15:0]        tc_5_reg;

    always_comb begin
        sq5        = {1'b0, sq_4_reg, 2'b00} + {3'b0, sq_4_reg};
        sq2x7      = {sq2_4_reg, 3'b000} - {3'b0, sq2_4_reg};
        sq2x11     = {1'b0, sq2_4_reg, 3'b000} + {3'b0, sq2_4_reg, 1'b0} + {4'b0, sq2_4_reg};
        off2_next  = '0;
        sens2_next = '0;
        if (lt_4_reg) begin
            off2_next  = {2'b0, sq5[36:1]};
            sens2_next = {3'b0, sq5[36:2]};
            if (lt2_4_reg) begin
                off2_next  = off2_next + {1'b0, sq2x7};
                sens2_next = sens2_next + {1'b0, sq2x11[37:1]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_en[5]) begin
            d1_5_reg    <= d1_4_reg;
            off2_5_reg  <= off2_next;
            sens2_5_reg <= sens2_next;
            off_5_reg   <= off_4_reg;
            sens_5_reg  <= sens_4_reg;
            tc_5_reg    <= tc_4_reg;
        end
    end

    // ---------------- stage 6: corrected OFF and SENS ----------------
    logic signed [39:0] offc_next, sensc_next, offc_6_reg, sensc_6_reg;
    logic [23:0]        d1_6_reg;
    logic [15:0]        tc_6_reg;

    always_comb begin
        offc_next  = {{5{off_5_reg[34]}}, off_5_reg} - $signed({2'b0, off2_5_reg});
        sensc_next = {{6{sens_5_reg[33]}}, sens_5_reg} - $signed({2'b0, sens2_5_reg});
    end

    always_ff @(posedge aclk) begin
        if (stg_en[6]) begin
            d1_6_reg    <= d1_5_reg;
            offc_6_reg  <= offc_next;
            sensc_6_reg <= sensc_next;
            tc_6_reg    <= tc_5_reg;
        end
    end

    // ---------------- stages 7-8: D1 * SENS ----------------
    mul_ctl_t           mul_ctl;
    logic signed [63:0] prod_8;
    logic signed [39:0] offc_7_reg, offc_8_reg;
    logic [15:0]        tc_7_reg, tc_8_reg;

    assign mul_ctl.pp_en  = stg_en[7];
    assign mul_ctl.sum_en = stg_en[8];

    bptc_wide_mul u_mul (
        .aclk (aclk),
        .ctl  (mul_ctl),
        .a    (d1_6_reg),
        .b    (sensc_6_reg),
        .p    (prod_8)
    );

    always_ff @(posedge aclk) begin
        if (stg_en[7]) begin
            offc_7_reg <= offc_6_reg;
            tc_7_reg   <= tc_6_reg;
        end
        if (stg_en[8]) begin
            offc_8_reg <= offc_7_reg;
            tc_8_reg   <= tc_7_reg;
        end
    end

    // ---------------- stage 9: / 2^21 ----------------
    logic signed [63:0] tp;
    logic signed [42:0] q_9_reg;
    logic signed [39:0] offc_9_reg;
    logic [15:0]        tc_9_reg;

    assign tp = prod_8 + $signed({43'b0, {21{prod_8[63]}}});

    always_ff @(posedge aclk) begin
        if (stg_en[9]) begin
            q_9_reg    <= tp[63:21];
            offc_9_reg <= offc_8_reg;
            tc_9_reg   <= tc_8_reg;
        end
    end

    // ---------------- stage 10: subtract OFF ----------------
    logic signed [43:0] diff_next, diff_10_reg;
    logic [15:0]        tc_10_reg;

    assign diff_next = {q_9_reg[42], q_9_reg} - {{4{offc_9_reg[39]}}, offc_9_reg};

    always_ff @(posedge aclk) begin
        if (stg_en[10]) begin
            diff_10_reg <= diff_next;
            tc_10_reg   <= tc_9_reg;
        end
    end

    // ---------------- stage 11: / 2^15, saturate, output register ----------------
    logic signed [43:0] td;
    logic signed [28:0] pq;
    logic [16:0]        pres_next, pres_11_reg;
    logic [15:0]        tc_11_reg;

    always_comb begin
        td = diff_10_reg + $signed({29'b0, {15{diff_10_reg[43]}}});
        pq = td[43:15];
        if (pq[28])             pres_next = '0;
        else if (pq > PRES_MAX) pres_next = PRES_MAX[16:0];
        else                    pres_next = pq[16:0];
    end

    always_ff @(posedge aclk) begin
        if (stg_en[11]) begin
            pres_11_reg <= pres_next;
            tc_11_reg   <= tc_10_reg;
        end
    end

    assign m_axis_tdata = {7'b0, tc_11_reg, pres_11_reg};

endmodule

@@ sv/bptc_checker.sv @@
// Port-level checker for the baro compensation top level, with its bind.
module bptc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // with nothing waiting at the output every stage can advance
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output empty");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // padding bits of the result stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[39:33] == 7'd0)
        else $error("result padding not zero");

endmodule

bind baro_pressure_temp_compensation_top bptc_checker u_bptc_checker (.*);
